@@ sv/isaac_plus_keystream_generator_top_defines.svh @@
// Assertion macros shared by the keystream generator RTL.
`ifndef ISAAC_PLUS_KEYSTREAM_GENERATOR_TOP_DEFINES_SVH
`define ISAAC_PLUS_KEYSTREAM_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, ignored in reset.
`define IPK_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on clock, ignored in reset.
`define IPK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ sv/ipk_pkg.sv @@
// Types, constants and mix helper for the keystream generator.
`default_nettype none
package ipk_pkg;
   localparam int SBOX_WORDS = 256;
   localparam int WORD_W     = 32;
   localparam int IDX_W      = $clog2(SBOX_WORDS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int HALF       = SBOX_WORDS / 2;
   localparam logic [WORD_W-1:0] GOLDEN = 32'h9e3779b9;

   localparam logic REQ_GET  = 1'b0;
   localparam logic REQ_SEED = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_R0,
      ST_R1,
      ST_R2,
      ST_R3,
      ST_R4,
      ST_GET_RD,
      ST_GET_OUT,
      ST_RK_INIT,
      ST_RK_LOAD,
      ST_RK_MIX,
      ST_RK_WRITE
   } state_type;

   typedef enum logic [1:0] {
      FK_GET,
      FK_REFILL,
      FK_SEED
   } fill_kind_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [WORD_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr;
   } ram_ctrl_type;

   typedef logic [7:0][WORD_W-1:0] mix_state_type;

   // Rotate schedule, picked by the low two bits of the round index: rotl 13 / rotr 6 / rotl 2 / rotr 16.
   function automatic logic [WORD_W-1:0] sched(logic [WORD_W-1:0] a, logic [1:0] ph);
      logic [WORD_W-1:0] r;
      case (ph)
         2'd0:    r = {a[18:0], a[31:19]};
         2'd1:    r = {a[5:0], a[31:6]};
         2'd2:    r = {a[29:0], a[31:30]};
         default: r = {a[15:0], a[31:16]};
      endcase
      return r;
   endfunction

   // One line of the eight-line golden-ratio mix.
   function automatic mix_state_type mix_line(mix_state_type t, logic [2:0] i);
      mix_state_type     r;
      logic [WORD_W-1:0] sh;
      logic [2:0]        i1;
      logic [2:0]        i2;
      logic [2:0]        i4;
      r  = t;
      i1 = i + 3'd1;
      i2 = i + 3'd2;
      i4 = i + 3'd4;
      case (i)
         3'd0:    sh = t[i1] << 11;
         3'd1:    sh = t[i1] >> 2;
         3'd2:    sh = t[i1] << 8;
         3'd3:    sh = t[i1] >> 16;
         3'd4:    sh = t[i1] << 10;
         3'd5:    sh = t[i1] >> 4;
         3'd6:    sh = t[i1] << 8;
         default: sh = t[i1] >> 9;
      endcase
      r[i]  = t[i] ^ sh;
      r[i4] = t[i4] + r[i];
      r[i1] = t[i1] + t[i2];
      return r;
   endfunction
endpackage
`default_nettype wire

@@ sv/ipk_if.sv @@
// Request and response channel interfaces.
`default_nettype none
interface ipk_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] seed_word;
   logic        seed_last;
   modport source (output valid, req_type, seed_word, seed_last, input ready);
   modport sink   (input valid, req_type, seed_word, seed_last, output ready);
endinterface

interface ipk_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] rand_word;
   modport source (output valid, rand_word, input ready);
   modport sink   (input valid, rand_word, output ready);
endinterface
`default_nettype wire

@@ sv/ipk_ram.sv @@
// 256 x 32 single-write, single-read memory with registered read data.
`default_nettype none
module ipk_ram
   import ipk_pkg::*;
(
   input  wire logic              clock,
   input  wire ram_ctrl_type      ctrl,
   output logic [WORD_W-1:0]      rdata
);
   logic [WORD_W-1:0] mem [SBOX_WORDS];

   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         mem[ctrl.waddr] <= ctrl.wdata;
      end
      rdata <= mem[ctrl.raddr];
   end
endmodule
`default_nettype wire

@@ sv/ipk_engine.sv @@
// Round sequencer: S-box clear, refill rounds, get responses, seeding and re-keying.
`default_nettype none
`include "isaac_plus_keystream_generator_top_defines.svh"
module ipk_engine
   import ipk_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   ipk_req_if.sink            req_chan,
   ipk_rsp_if.source          rsp_chan,
   output ram_ctrl_type       sbox_ctrl,
   output ram_ctrl_type       res_ctrl,
   output ram_ctrl_type       seed_ctrl,
   input  wire logic [WORD_W-1:0] sbox_rdata,
   input  wire logic [WORD_W-1:0] res_rdata,
   input  wire logic [WORD_W-1:0] seed_rdata
);
   state_type         state_ff, state_in;
   fill_kind_type     kind_ff, kind_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] y_ff, y_in;
   logic [WORD_W-1:0] acc_a_ff, acc_a_in;
   logic [WORD_W-1:0] acc_b_ff, acc_b_in;
   logic [WORD_W-1:0] rc_ff, rc_in;
   logic [CNT_W-1:0]  words_left_ff, words_left_in;
   logic [CNT_W-1:0]  seed_fill_ff, seed_fill_in;
   logic [CNT_W-1:0]  seed_n_ff, seed_n_in;
   logic [IDX_W-1:0]  seed_idx_ff, seed_idx_in;
   mix_state_type     t_ff, t_in;
   logic [2:0]        line_ff, line_in;
   logic [1:0]        rep_ff, rep_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [4:0]        blk_ff, blk_in;
   logic              pass_ff, pass_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              rsp_free;
   logic              chunk_end;
   logic [CNT_W-1:0]  seed_next;
   logic [WORD_W-1:0] y_val;
   logic [WORD_W-1:0] fwd_val;
   logic [WORD_W-1:0] b_val;
   logic              start_fill;
   fill_kind_type     start_kind;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.rand_word = rsp_data_ff;

   assign accept    = req_chan.valid && req_chan.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign seed_next = {1'b0, seed_fill_ff[IDX_W-1:0]} + CNT_W'(1);
   assign chunk_end = req_chan.seed_last || (seed_next == CNT_W'(SBOX_WORDS));
   assign y_val     = acc_a_ff ^ (acc_b_ff + sbox_rdata);
   // forward the word written in the previous phase when the lookup hits it
   assign fwd_val   = (y_ff[17:10] == k_ff) ? y_ff : sbox_rdata;
   assign b_val     = x_ff + (acc_a_ff ^ fwd_val);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (k_ff == IDX_W'(SBOX_WORDS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.req_type == REQ_GET) begin
                  state_in = (words_left_ff == '0) ? ST_R0 : ST_GET_RD;
               end else if (chunk_end) begin
                  state_in = ST_R0;
               end
            end
         end
         ST_R0:       state_in = ST_R1;
         ST_R1:       state_in = ST_R2;
         ST_R2:       state_in = ST_R3;
         ST_R3:       state_in = ST_R4;
         ST_R4: begin
            if (k_ff != IDX_W'(SBOX_WORDS - 1)) begin
               state_in = ST_R0;
            end else begin
               case (kind_ff)
                  FK_GET:  state_in = ST_GET_RD;
                  FK_SEED: state_in = ST_RK_INIT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_GET_RD:   state_in = ST_GET_OUT;
         ST_GET_OUT: begin
            if (rsp_free) begin
               state_in = (words_left_ff == CNT_W'(1)) ? ST_R0 : ST_IDLE;
            end
         end
         ST_RK_INIT:  if (line_ff == 3'd7 && rep_ff == 2'd3) state_in = ST_RK_LOAD;
         ST_RK_LOAD:  if (cnt_ff == 4'd8) state_in = ST_RK_MIX;
         ST_RK_MIX:   if (line_ff == 3'd7) state_in = ST_RK_WRITE;
         ST_RK_WRITE: begin
            if (cnt_ff == 4'd7) begin
               state_in = (blk_ff == 5'd31 && pass_ff) ? ST_R0 : ST_RK_LOAD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      kind_in       = kind_ff;
      k_in          = k_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_a_in      = acc_a_ff;
      acc_b_in      = acc_b_ff;
      rc_in         = rc_ff;
      words_left_in = words_left_ff;
      seed_fill_in  = seed_fill_ff;
      seed_n_in     = seed_n_ff;
      seed_idx_in   = seed_idx_ff;
      t_in          = t_ff;
      line_in       = line_ff;
      rep_in        = rep_ff;
      cnt_in        = cnt_ff;
      blk_in        = blk_ff;
      pass_in       = pass_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      sbox_ctrl     = '0;
      res_ctrl      = '0;
      seed_ctrl     = '0;
      // hold the seed read address so the word is still there in the last phase
      seed_ctrl.raddr = seed_idx_ff;
      start_fill    = 1'b0;
      start_kind    = FK_REFILL;

      case (state_ff)
         ST_CLEAR: begin
            sbox_ctrl.we    = 1'b1;
            sbox_ctrl.waddr = k_ff;
            k_in            = k_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.req_type == REQ_GET) begin
                  if (words_left_ff == '0) begin
                     start_fill = 1'b1;
                     start_kind = FK_GET;
                  end
               end else begin
                  seed_ctrl.we    = 1'b1;
                  seed_ctrl.waddr = seed_fill_ff[IDX_W-1:0];
                  seed_ctrl.wdata = req_chan.seed_word;
                  if (chunk_end) begin
                     seed_n_in    = seed_next;
                     seed_fill_in = '0;
                     seed_idx_in  = '0;
                     start_fill   = 1'b1;
                     start_kind   = FK_SEED;
                  end else begin
                     seed_fill_in = seed_next;
                  end
               end
            end
         end
         ST_R0: begin
            sbox_ctrl.raddr = k_ff;
         end
         ST_R1: begin
            x_in            = sbox_rdata;
            sbox_ctrl.raddr = k_ff + IDX_W'(HALF);
         end
         ST_R2: begin
            acc_a_in        = sched(acc_a_ff, k_ff[1:0]) + sbox_rdata;
            sbox_ctrl.raddr = x_ff[IDX_W+1:2];
         end
         ST_R3: begin
            y_in            = y_val;
            sbox_ctrl.we    = 1'b1;
            sbox_ctrl.waddr = k_ff;
            sbox_ctrl.wdata = y_val;
            sbox_ctrl.raddr = y_val[17:10];
         end
         ST_R4: begin
            acc_b_in       = b_val;
            res_ctrl.we    = 1'b1;
            res_ctrl.waddr = k_ff;
            res_ctrl.wdata = (kind_ff == FK_SEED) ? (b_val ^ seed_rdata) : b_val;
            seed_idx_in    = (({1'b0, seed_idx_ff} + CNT_W'(1)) == seed_n_ff) ?
                             '0 : seed_idx_ff + IDX_W'(1);
            k_in           = k_ff + IDX_W'(1);
            if (k_ff == IDX_W'(SBOX_WORDS - 1)) begin
               if (kind_ff == FK_SEED) begin
                  t_in    = {8{GOLDEN}};
                  line_in = '0;
                  rep_in  = '0;
               end else begin
                  words_left_in = CNT_W'(SBOX_WORDS);
               end
            end
         end
         ST_GET_RD: begin
            res_ctrl.raddr = IDX_W'(~words_left_ff[IDX_W-1:0] + IDX_W'(1));
         end
         ST_GET_OUT: begin
            // keep the read address while the response register is busy
            res_ctrl.raddr = IDX_W'(~words_left_ff[IDX_W-1:0] + IDX_W'(1));
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_rdata;
               words_left_in = words_left_ff - CNT_W'(1);
               if (words_left_ff == CNT_W'(1)) begin
                  start_fill = 1'b1;
                  start_kind = FK_REFILL;
               end
            end
         end
         ST_RK_INIT: begin
            t_in    = mix_line(t_ff, line_ff);
            line_in = line_ff + 3'd1;
            if (line_ff == 3'd7) begin
               rep_in = rep_ff + 2'd1;
               if (rep_ff == 2'd3) begin
                  cnt_in  = '0;
                  blk_in  = '0;
                  pass_in = 1'b0;
               end
            end
         end
         ST_RK_LOAD: begin
            sbox_ctrl.raddr = {blk_ff, cnt_ff[2:0]};
            res_ctrl.raddr  = {blk_ff, cnt_ff[2:0]};
            if (cnt_ff != 4'd0) begin
               t_in[cnt_ff[2:0] - 3'd1] = t_ff[cnt_ff[2:0] - 3'd1] +
                                          (pass_ff ? sbox_rdata : res_rdata);
            end
            cnt_in  = cnt_ff + 4'd1;
            line_in = '0;
         end
         ST_RK_MIX: begin
            t_in    = mix_line(t_ff, line_ff);
            line_in = line_ff + 3'd1;
            cnt_in  = '0;
         end
         ST_RK_WRITE: begin
            sbox_ctrl.we    = 1'b1;
            sbox_ctrl.waddr = {blk_ff, cnt_ff[2:0]};
            sbox_ctrl.wdata = t_ff[cnt_ff[2:0]];
            cnt_in          = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) begin
               cnt_in = '0;
               blk_in = blk_ff + 5'd1;
               if (blk_ff == 5'd31) begin
                  if (pass_ff) begin
                     start_fill = 1'b1;
                     start_kind = FK_REFILL;
                  end else begin
                     pass_in = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // every fill pass (get, refill or seed) bumps the round counter into acc_b first
      if (start_fill) begin
         kind_in  = start_kind;
         k_in     = '0;
         rc_in    = rc_ff + WORD_W'(1);
         acc_b_in = acc_b_ff + rc_ff + WORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         k_ff          <= '0;
         acc_a_ff      <= '0;
         acc_b_ff      <= '0;
         rc_ff         <= '0;
         words_left_ff <= '0;
         seed_fill_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         kind_ff       <= FK_REFILL;
         line_ff       <= '0;
         rep_ff        <= '0;
         cnt_ff        <= '0;
         blk_ff        <= '0;
         pass_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         acc_a_ff      <= acc_a_in;
         acc_b_ff      <= acc_b_in;
         rc_ff         <= rc_in;
         words_left_ff <= words_left_in;
         seed_fill_ff  <= seed_fill_in;
         rsp_valid_ff  <= rsp_valid_in;
         kind_ff       <= kind_in;
         line_ff       <= line_in;
         rep_ff        <= rep_in;
         cnt_ff        <= cnt_in;
         blk_ff        <= blk_in;
         pass_ff       <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      seed_n_ff   <= seed_n_in;
      seed_idx_ff <= seed_idx_in;
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
   end

   `IPK_ASSERT_IMPL(a_words_left_range, 1'b1, words_left_ff <= CNT_W'(SBOX_WORDS))
   `IPK_ASSERT_IMPL(a_seed_fill_range, 1'b1, seed_fill_ff < CNT_W'(SBOX_WORDS))
   `IPK_ASSERT_IMPL(a_rsp_from_get, $rose(rsp_valid_ff), $past(state_ff) == ST_GET_OUT)
   `IPK_ASSERT_NEXT(a_get_not_empty, state_ff == ST_GET_RD, words_left_ff != '0)
endmodule
`default_nettype wire

@@ sv/isaac_plus_keystream_generator_top.sv @@
// Top level of the ISAAC+ keystream generator.
// After reset the S-box is cleared word by word; no request is taken
// meanwhile. A get passes from acceptance through ST_GET_RD and ST_GET_OUT
// to a loaded response register, waiting in ST_GET_OUT while that register
// is busy; the response register frees the input side while the result
// waits. A refill of the 256-word result store runs 256 rounds through
// ST_R0 to ST_R4, as every round visits the single S-box read port four
// times; it runs after the get that empties the store, before the first get
// after reset and after a re-key. A seed word is written on acceptance, but
// the word that ends a chunk costs a buffer fill, a re-key (initial mixing,
// then 2 passes of 32 blocks) and a refill; no request is taken meanwhile.
`default_nettype none
module isaac_plus_keystream_generator_top
   import ipk_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ipk_req_if.sink   req_chan,
   ipk_rsp_if.source rsp_chan
);
   ram_ctrl_type      sbox_ctrl;
   ram_ctrl_type      res_ctrl;
   ram_ctrl_type      seed_ctrl;
   logic [WORD_W-1:0] sbox_rdata;
   logic [WORD_W-1:0] res_rdata;
   logic [WORD_W-1:0] seed_rdata;

   ipk_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .sbox_ctrl  (sbox_ctrl),
      .res_ctrl   (res_ctrl),
      .seed_ctrl  (seed_ctrl),
      .sbox_rdata (sbox_rdata),
      .res_rdata  (res_rdata),
      .seed_rdata (seed_rdata)
   );

   ipk_ram u_sbox (
      .clock (clock),
      .ctrl  (sbox_ctrl),
      .rdata (sbox_rdata)
   );

   ipk_ram u_result (
      .clock (clock),
      .ctrl  (res_ctrl),
      .rdata (res_rdata)
   );

   ipk_ram u_seed (
      .clock (clock),
      .ctrl  (seed_ctrl),
      .rdata (seed_rdata)
   );
endmodule
`default_nettype wire
